// File: hw/rtl/ibapfc_pkg.sv
// Package: sizes, codes, reset values and counter helpers for ingress buffer accounting.
package ibapfc_pkg;

  localparam int NUM_PORTS   = 32;
  localparam int NUM_CLASSES = 8;
  localparam int COUNT_BITS  = 24;

  localparam int PORT_W  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int CLS_W   = $clog2(NUM_CLASSES);
  localparam int ENT_W   = PORT_W + CLS_W;
  localparam int ENTRIES = NUM_PORTS * (1 << CLS_W);

  localparam int OP_W         = 1;
  localparam int IN_PORT_W    = 5;
  localparam int TC_W         = 3;
  localparam int BYTES_W      = 16;
  localparam int MASK_W       = 8;
  localparam int OUT_W        = 24;
  localparam int THR_W        = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int CMP_W        = 33;

  localparam logic [TC_W-1:0]   LOSSY_CLASS = TC_W'(1);
  localparam logic [MASK_W-1:0] ALL_CLASSES = MASK_W'((1 << NUM_CLASSES) - 1);
  localparam logic [MASK_W-1:0] LOSSY_BIT   = MASK_W'(1) << LOSSY_CLASS;

  localparam logic [THR_W-1:0] POOL_HDRM_THR_RST    = THR_W'(4000 * 1030);
  localparam logic [THR_W-1:0] CLASS_PAUSE_THR_RST  = THR_W'(20 * 1030);
  localparam logic [THR_W-1:0] PORT_PAUSE_THR_RST   = THR_W'(4800 * 1030);
  localparam logic [THR_W-1:0] CLASS_RESUME_THR_RST = THR_W'(20 * 1030 - 2 * 1030);
  localparam logic [THR_W-1:0] PORT_RESUME_THR_RST  = THR_W'(4700 * 1030);

  typedef enum logic [OP_W-1:0] {
    OP_ADMIT,
    OP_RELEASE
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_HDRM_THR,
    CFG_CLASS_PAUSE_THR,
    CFG_PORT_PAUSE_THR,
    CFG_CLASS_RESUME_THR,
    CFG_PORT_RESUME_THR,
    CFG_PFC_ON_LOSSY
  } cfg_idx_e;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  typedef struct packed {
    cnt_t cls;
    cnt_t hdrm;
  } ent_t;

  function automatic cnt_t sat_add(cnt_t a, logic [BYTES_W-1:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS + 1)'(b);
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  function automatic cnt_t floor_sub(cnt_t a, logic [BYTES_W-1:0] b);
    return (a > COUNT_BITS'(b)) ? a - COUNT_BITS'(b) : '0;
  endfunction

endpackage

// File: hw/rtl/ibapfc_if.sv
// Interfaces: request and response channels with valid/ready handshake.
interface ibapfc_req_if import ibapfc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [IN_PORT_W-1:0] in_port;
  logic [TC_W-1:0]      traffic_class;
  logic [BYTES_W-1:0]   pkt_bytes;

  modport source (output valid, output op, output in_port, output traffic_class,
                  output pkt_bytes, input ready);
  modport sink   (input valid, input op, input in_port, input traffic_class,
                  input pkt_bytes, output ready);
endinterface

interface ibapfc_rsp_if import ibapfc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] pause_mask;
  logic              resume_ok;
  logic [OUT_W-1:0]  port_used;
  logic [OUT_W-1:0]  class_used;
  logic [OUT_W-1:0]  headroom_used;
  logic [OUT_W-1:0]  total_used;

  modport source (output valid, output pause_mask, output resume_ok, output port_used,
                  output class_used, output headroom_used, output total_used, input ready);
  modport sink   (input valid, input pause_mask, input resume_ok, input port_used,
                  input class_used, input headroom_used, input total_used, output ready);
endinterface

// File: hw/rtl/ingress_buffer_accounting_pfc.sv
// Top level: ingress buffer accounting with PFC pause mask and resume decision.
// An accepted transaction is loaded into stage s1 together with the counter memory reads,
// and the result is registered from s1 into the output register. No new transaction is
// taken while s1 holds one: the port and class/headroom counters are written back from s1.
// A new request is taken only when the output register is empty or drains in that cycle.
// Reset (async, active low): thresholds to defaults, counters read as zero via valid bits.
module ingress_buffer_accounting_pfc import ibapfc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  ibapfc_req_if.sink            req_i,
  ibapfc_rsp_if.source          rsp_o
);

  logic [THR_W-1:0] pool_hdrm_thr_q, class_pause_thr_q, port_pause_thr_q;
  logic [THR_W-1:0] class_resume_thr_q, port_resume_thr_q;
  logic             pfc_on_lossy_q;

  logic               s1_q;
  logic [OP_W-1:0]    s1_op_q;
  logic               s1_in_range_q;
  logic               s1_lossy_q;
  logic [PORT_W-1:0]  s1_port_q;
  logic [CLS_W-1:0]   s1_cls_q;
  logic [BYTES_W-1:0] s1_bytes_q;

  cnt_t               port_mem [NUM_PORTS];
  cnt_t               port_rd_q;
  logic [NUM_PORTS-1:0] port_vld_q;
  ent_t               ent_mem [ENTRIES];
  ent_t               ent_rd_q;
  logic [ENTRIES-1:0] ent_vld_q;

  cnt_t total_q;
  cnt_t pool_q [2];

  logic              out_valid_q;
  logic [MASK_W-1:0] pause_mask_q;
  logic              resume_ok_q;
  logic [OUT_W-1:0]  port_used_q, class_used_q, headroom_used_q, total_used_q;

  logic              req_fire;
  logic              in_range;
  logic [PORT_W-1:0] rd_port;
  logic [ENT_W-1:0]  rd_ent;
  logic [ENT_W-1:0]  s1_ent;
  logic              wr_en;
  cnt_t              port_old, cls_old, hdrm_old, pool_old;
  cnt_t              total_d, pool_d, port_d, cls_d, hdrm_d;
  logic              exempt;
  logic [MASK_W-1:0] mask_d;
  logic              resume_d;

  assign req_i.ready = !s1_q && (!out_valid_q || rsp_o.ready);
  assign req_fire    = req_i.valid && req_i.ready;
  assign in_range    = (int'(req_i.in_port) < NUM_PORTS)
                    && (int'(req_i.traffic_class) < NUM_CLASSES);
  assign rd_port     = PORT_W'(req_i.in_port);
  assign rd_ent      = {rd_port, CLS_W'(req_i.traffic_class)};
  assign s1_ent      = {s1_port_q, s1_cls_q};
  assign wr_en       = s1_q && s1_in_range_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_hdrm_thr_q    <= POOL_HDRM_THR_RST;
      class_pause_thr_q  <= CLASS_PAUSE_THR_RST;
      port_pause_thr_q   <= PORT_PAUSE_THR_RST;
      class_resume_thr_q <= CLASS_RESUME_THR_RST;
      port_resume_thr_q  <= PORT_RESUME_THR_RST;
      pfc_on_lossy_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POOL_HDRM_THR:    pool_hdrm_thr_q    <= THR_W'(cfg_wdata_i);
        CFG_CLASS_PAUSE_THR:  class_pause_thr_q  <= THR_W'(cfg_wdata_i);
        CFG_PORT_PAUSE_THR:   port_pause_thr_q   <= THR_W'(cfg_wdata_i);
        CFG_CLASS_RESUME_THR: class_resume_thr_q <= THR_W'(cfg_wdata_i);
        CFG_PORT_RESUME_THR:  port_resume_thr_q  <= THR_W'(cfg_wdata_i);
        CFG_PFC_ON_LOSSY:     pfc_on_lossy_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
    end else begin
      s1_q <= req_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_op_q       <= req_i.op;
      s1_in_range_q <= in_range;
      s1_lossy_q    <= (req_i.traffic_class == LOSSY_CLASS);
      s1_port_q     <= rd_port;
      s1_cls_q      <= CLS_W'(req_i.traffic_class);
      s1_bytes_q    <= req_i.pkt_bytes;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire && in_range) begin
      port_rd_q <= port_mem[rd_port];
    end
    if (wr_en) begin
      port_mem[s1_port_q] <= port_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire && in_range) begin
      ent_rd_q <= ent_mem[rd_ent];
    end
    if (wr_en) begin
      ent_mem[s1_ent] <= '{cls: cls_d, hdrm: hdrm_d};
    end
  end

  always_comb begin
    port_old = port_vld_q[s1_port_q] ? port_rd_q : '0;
    cls_old  = ent_vld_q[s1_ent] ? ent_rd_q.cls : '0;
    hdrm_old = ent_vld_q[s1_ent] ? ent_rd_q.hdrm : '0;
    pool_old = pool_q[s1_lossy_q];
    if (s1_op_q == OP_ADMIT) begin
      total_d = sat_add(total_q, s1_bytes_q);
      pool_d  = sat_add(pool_old, s1_bytes_q);
      port_d  = sat_add(port_old, s1_bytes_q);
      cls_d   = sat_add(cls_old, s1_bytes_q);
      hdrm_d  = (CMP_W'(pool_d) > CMP_W'(pool_hdrm_thr_q))
                ? sat_add(hdrm_old, s1_bytes_q) : hdrm_old;
    end else begin
      total_d = floor_sub(total_q, s1_bytes_q);
      pool_d  = floor_sub(pool_old, s1_bytes_q);
      port_d  = floor_sub(port_old, s1_bytes_q);
      cls_d   = floor_sub(cls_old, s1_bytes_q);
      hdrm_d  = floor_sub(hdrm_old, s1_bytes_q);
    end
    exempt = !pfc_on_lossy_q;
    if (CMP_W'(port_d) > CMP_W'(port_pause_thr_q)) begin
      mask_d = ALL_CLASSES & ~(exempt ? LOSSY_BIT : '0);
    end else if ((CMP_W'(cls_d) > CMP_W'(class_pause_thr_q)) && !(s1_lossy_q && exempt)) begin
      mask_d = MASK_W'(1) << s1_cls_q;
    end else begin
      mask_d = '0;
    end
    resume_d = (CMP_W'(cls_d) < CMP_W'(class_resume_thr_q))
            && (CMP_W'(port_d) < CMP_W'(port_resume_thr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      pool_q[0]  <= '0;
      pool_q[1]  <= '0;
      port_vld_q <= '0;
      ent_vld_q  <= '0;
    end else if (wr_en) begin
      total_q              <= total_d;
      pool_q[s1_lossy_q]   <= pool_d;
      port_vld_q[s1_port_q] <= 1'b1;
      ent_vld_q[s1_ent]    <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_q) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      if (s1_in_range_q) begin
        pause_mask_q    <= mask_d;
        resume_ok_q     <= resume_d;
        port_used_q     <= OUT_W'(port_d);
        class_used_q    <= OUT_W'(cls_d);
        headroom_used_q <= OUT_W'(hdrm_d);
        total_used_q    <= OUT_W'(total_d);
      end else begin
        pause_mask_q    <= '0;
        resume_ok_q     <= 1'b0;
        port_used_q     <= '0;
        class_used_q    <= '0;
        headroom_used_q <= '0;
        total_used_q    <= OUT_W'(total_q);
      end
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.pause_mask    = pause_mask_q;
  assign rsp_o.resume_ok     = resume_ok_q;
  assign rsp_o.port_used     = port_used_q;
  assign rsp_o.class_used    = class_used_q;
  assign rsp_o.headroom_used = headroom_used_q;
  assign rsp_o.total_used    = total_used_q;

  a_no_accept_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q |-> !req_i.ready)
    else $error("request accepted during read-modify-write");

  a_out_free_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q |-> !out_valid_q)
    else $error("output register occupied while a transaction is in flight");

  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> s1_q ##1 out_valid_q)
    else $error("accepted transaction produced no result");

  a_release_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q && s1_op_q == OP_RELEASE) |=> total_q <= $past(total_q))
    else $error("release increased the total counter");

endmodule

// File: tb/tb_top.sv
// Testbench for ingress buffer accounting: random admit/release traffic checked against a predictor.
module tb_top import ibapfc_pkg::*; ();

  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned HOLD_OFF_CYCLES = 150;
  localparam int unsigned BYTES_MAX       = (1 << BYTES_W) - 1;
  localparam int unsigned THR_MAX         = (1 << THR_W) - 1;

  typedef enum int unsigned {
    RX_STREAM,
    RX_COIN,
    RX_ONE_IN_THREE,
    RX_MOSTLY
  } rx_mode_e;

  typedef struct packed {
    op_e                  op;
    logic [IN_PORT_W-1:0] port;
    logic [TC_W-1:0]      cls;
    logic [BYTES_W-1:0]   bytes;
  } acct_req_t;

  typedef struct packed {
    logic [MASK_W-1:0] pause_mask;
    logic              resume_ok;
    logic [OUT_W-1:0]  port_used;
    logic [OUT_W-1:0]  class_used;
    logic [OUT_W-1:0]  headroom_used;
    logic [OUT_W-1:0]  total_used;
  } pfc_report_t;

  class pfc_ledger;
    logic [THR_W-1:0] hdrm_thr;
    logic [THR_W-1:0] cls_pause_thr;
    logic [THR_W-1:0] port_pause_thr;
    logic [THR_W-1:0] cls_resume_thr;
    logic [THR_W-1:0] port_resume_thr;
    logic             lossy_pause;
    cnt_t             total_q;
    cnt_t             pool_q [2];
    cnt_t             port_q [NUM_PORTS];
    cnt_t             cls_q  [NUM_PORTS*NUM_CLASSES];
    cnt_t             hdrm_q [NUM_PORTS*NUM_CLASSES];
    pfc_report_t      expected_reports [$];
    int unsigned      mismatches;

    function new();
      hdrm_thr        = POOL_HDRM_THR_RST;
      cls_pause_thr   = CLASS_PAUSE_THR_RST;
      port_pause_thr  = PORT_PAUSE_THR_RST;
      cls_resume_thr  = CLASS_RESUME_THR_RST;
      port_resume_thr = PORT_RESUME_THR_RST;
      lossy_pause     = 1'b1;
      total_q         = '0;
      foreach (pool_q[i]) pool_q[i] = '0;
      foreach (port_q[i]) port_q[i] = '0;
      foreach (cls_q[i]) begin
        cls_q[i]  = '0;
        hdrm_q[i] = '0;
      end
      mismatches = 0;
    endfunction

    function cnt_t grow(cnt_t a, logic [BYTES_W-1:0] b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + (COUNT_BITS + 1)'(b);
      return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
    endfunction

    function cnt_t shrink(cnt_t a, logic [BYTES_W-1:0] b);
      return (a > COUNT_BITS'(b)) ? a - COUNT_BITS'(b) : '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_POOL_HDRM_THR:    hdrm_thr = val;
        CFG_CLASS_PAUSE_THR:  cls_pause_thr = val;
        CFG_PORT_PAUSE_THR:   port_pause_thr = val;
        CFG_CLASS_RESUME_THR: cls_resume_thr = val;
        CFG_PORT_RESUME_THR:  port_resume_thr = val;
        CFG_PFC_ON_LOSSY:     lossy_pause = val[0];
        default: ;
      endcase
    endfunction

    function void account(acct_req_t it);
      pfc_report_t rep;
      int unsigned pool_sel;
      int unsigned slot;
      logic        exempt;
      rep      = '0;
      exempt   = !lossy_pause;
      pool_sel = (it.cls == LOSSY_CLASS) ? 1 : 0;
      slot     = it.port * NUM_CLASSES + it.cls;
      if (it.op == OP_ADMIT) begin
        total_q          = grow(total_q, it.bytes);
        pool_q[pool_sel] = grow(pool_q[pool_sel], it.bytes);
        port_q[it.port]  = grow(port_q[it.port], it.bytes);
        cls_q[slot]      = grow(cls_q[slot], it.bytes);
        if (pool_q[pool_sel] > hdrm_thr) hdrm_q[slot] = grow(hdrm_q[slot], it.bytes);
      end else begin
        total_q          = shrink(total_q, it.bytes);
        pool_q[pool_sel] = shrink(pool_q[pool_sel], it.bytes);
        port_q[it.port]  = shrink(port_q[it.port], it.bytes);
        cls_q[slot]      = shrink(cls_q[slot], it.bytes);
        hdrm_q[slot]     = shrink(hdrm_q[slot], it.bytes);
      end
      if (port_q[it.port] > port_pause_thr) begin
        for (int unsigned c = 0; c < NUM_CLASSES; c++)
          if (!(c == LOSSY_CLASS && exempt)) rep.pause_mask[c] = 1'b1;
      end else if (cls_q[slot] > cls_pause_thr && !(it.cls == LOSSY_CLASS && exempt)) begin
        rep.pause_mask[it.cls] = 1'b1;
      end
      rep.resume_ok     = (cls_q[slot] < cls_resume_thr) && (port_q[it.port] < port_resume_thr);
      rep.port_used     = port_q[it.port];
      rep.class_used    = cls_q[slot];
      rep.headroom_used = hdrm_q[slot];
      rep.total_used    = total_q;
      expected_reports.push_back(rep);
    endfunction

    function void match_field(string field, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_report(pfc_report_t got);
      pfc_report_t want;
      if (expected_reports.size() == 0) begin
        $error("report with no transaction outstanding");
        mismatches++;
        return;
      end
      want = expected_reports.pop_front();
      match_field("pause_mask", want.pause_mask, got.pause_mask);
      match_field("resume_ok", want.resume_ok, got.resume_ok);
      match_field("port_used", want.port_used, got.port_used);
      match_field("class_used", want.class_used, got.class_used);
      match_field("headroom_used", want.headroom_used, got.headroom_used);
      match_field("total_used", want.total_used, got.total_used);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ibapfc_req_if req ();
  ibapfc_rsp_if rsp ();

  pfc_ledger   ledger = new();
  acct_req_t   held_packets [$];
  int unsigned burst_left = 0;
  int unsigned hold_off_asks = 0;
  int unsigned hold_off_done = 0;
  int unsigned quiet_cycles = 0;

  ingress_buffer_accounting_pfc u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    pfc_report_t got;
    acct_req_t   seen;
    if (rst_n) begin
      if (rsp.valid && rsp.ready) begin
        got.pause_mask    = rsp.pause_mask;
        got.resume_ok     = rsp.resume_ok;
        got.port_used     = rsp.port_used;
        got.class_used    = rsp.class_used;
        got.headroom_used = rsp.headroom_used;
        got.total_used    = rsp.total_used;
        ledger.check_report(got);
      end
      if (req.valid && req.ready) begin
        seen.op    = op_e'(req.op);
        seen.port  = req.in_port;
        seen.cls   = req.traffic_class;
        seen.bytes = req.pkt_bytes;
        ledger.account(seen);
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : rsp_stall_pattern
    rx_mode_e    mode;
    int unsigned span;
    int unsigned hold_left;
    int unsigned tick;
    span      = 0;
    hold_left = 0;
    tick      = 0;
    mode      = RX_STREAM;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_done != hold_off_asks) begin
        hold_off_done = hold_off_asks;
        hold_left     = HOLD_OFF_CYCLES;
      end
      if (span == 0) begin
        mode = rx_mode_e'($urandom_range(RX_STREAM, RX_MOSTLY));
        span = $urandom_range(16, 96);
      end
      span--;
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        case (mode)
          RX_STREAM:       rsp.ready <= 1'b1;
          RX_COIN:         rsp.ready <= 1'($urandom_range(0, 1));
          RX_ONE_IN_THREE: rsp.ready <= (tick % 3 == 0);
          default:         rsp.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic offer(op_e op, int unsigned port, int unsigned cls, int unsigned bytes);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 12);
    end
    burst_left--;
    req.valid         <= 1'b1;
    req.op            <= op;
    req.in_port       <= IN_PORT_W'(port);
    req.traffic_class <= TC_W'(cls);
    req.pkt_bytes     <= BYTES_W'(bytes);
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  function automatic acct_req_t mixed_item();
    acct_req_t   it;
    int unsigned roll;
    int unsigned pick;
    int unsigned size_roll;
    roll = $urandom_range(0, 99);
    if (roll < 55 || held_packets.size() == 0) begin
      it.op = OP_ADMIT;
      pick  = $urandom_range(0, 9);
      it.port = (pick < 3) ? 5'd3 : (pick < 5) ? 5'd17 : (pick < 7) ? 5'd30 :
                IN_PORT_W'($urandom_range(0, NUM_PORTS - 1));
      it.cls = ($urandom_range(0, 3) == 0) ? LOSSY_CLASS : TC_W'($urandom_range(0, 7));
      size_roll = $urandom_range(0, 9);
      if (size_roll < 3) it.bytes = BYTES_W'($urandom_range(32768, BYTES_MAX));
      else if (size_roll < 8) it.bytes = BYTES_W'($urandom_range(64, 1518));
      else if (size_roll < 9) it.bytes = BYTES_W'($urandom_range(0, 63));
      else it.bytes = BYTES_W'($urandom_range(0, BYTES_MAX));
      if (held_packets.size() < 256) held_packets.push_back(it);
    end else if (roll < 90) begin
      pick = $urandom_range(0, held_packets.size() - 1);
      it   = held_packets[pick];
      held_packets.delete(pick);
      it.op = OP_RELEASE;
    end else begin
      it.op    = ($urandom_range(0, 1) != 0) ? OP_RELEASE : OP_ADMIT;
      it.port  = IN_PORT_W'($urandom_range(0, NUM_PORTS - 1));
      it.cls   = TC_W'($urandom_range(0, 7));
      it.bytes = BYTES_W'($urandom_range(0, BYTES_MAX));
    end
    return it;
  endfunction

  task automatic run_mixed(int unsigned count);
    acct_req_t it;
    repeat (count) begin
      it = mixed_item();
      offer(it.op, it.port, it.cls, it.bytes);
    end
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (ledger.expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    ledger.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_regs(int unsigned hdrm, int unsigned cls_pause, int unsigned port_pause,
                              int unsigned cls_resume, int unsigned port_resume,
                              int unsigned lossy);
    write_reg(CFG_POOL_HDRM_THR, CFG_DATA_W'(hdrm));
    write_reg(CFG_CLASS_PAUSE_THR, CFG_DATA_W'(cls_pause));
    write_reg(CFG_PORT_PAUSE_THR, CFG_DATA_W'(port_pause));
    write_reg(CFG_CLASS_RESUME_THR, CFG_DATA_W'(cls_resume));
    write_reg(CFG_PORT_RESUME_THR, CFG_DATA_W'(port_resume));
    write_reg(CFG_PFC_ON_LOSSY, CFG_DATA_W'(lossy));
  endtask

  initial begin : stimulus
    int unsigned flood_port;
    req.valid         <= 1'b0;
    req.op            <= OP_ADMIT;
    req.in_port       <= '0;
    req.traffic_class <= '0;
    req.pkt_bytes     <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_POOL_HDRM_THR;
    cfg_wdata         <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(OP_RELEASE, 0, 0, 100);
    offer(OP_ADMIT, 0, 0, 0);
    offer(OP_ADMIT, 0, 0, BYTES_MAX);
    offer(OP_ADMIT, 31, 7, BYTES_MAX);
    offer(OP_ADMIT, 31, LOSSY_CLASS, BYTES_MAX);
    offer(OP_RELEASE, 31, LOSSY_CLASS, 47000);
    offer(OP_ADMIT, 31, LOSSY_CLASS, 2100);
    offer(OP_RELEASE, 0, 0, BYTES_MAX);
    offer(OP_RELEASE, 0, 0, 1);
    for (int c = 0; c < NUM_CLASSES; c++) offer(OP_ADMIT, 16, c, 20601 + c);
    offer(OP_RELEASE, 16, 3, BYTES_MAX);
    offer(OP_RELEASE, 31, 7, BYTES_MAX);
    offer(OP_ADMIT, 21, 5, 16'h5555);
    offer(OP_ADMIT, 10, 2, 16'hAAAA);
    settle();

    program_regs($urandom_range(0, 300000), $urandom_range(0, 60000),
                 $urandom_range(0, 200000), $urandom_range(0, 60000),
                 $urandom_range(0, 200000), 0);
    hold_off_asks++;
    run_mixed(150);
    settle();

    program_regs(0, 0, 0, 0, 0, 1);
    run_mixed(80);
    settle();

    // drive one port/class to saturation, then release past zero
    program_regs(0, THR_MAX, THR_MAX, THR_MAX, THR_MAX, 0);
    hold_off_asks++;
    flood_port = $urandom_range(0, NUM_PORTS - 1);
    repeat (265) offer(OP_ADMIT, flood_port, LOSSY_CLASS, $urandom_range(64000, BYTES_MAX));
    repeat (270) offer(OP_RELEASE, flood_port, LOSSY_CLASS, $urandom_range(64000, BYTES_MAX));
    settle();

    program_regs($urandom_range(0, THR_MAX), $urandom_range(0, THR_MAX),
                 $urandom_range(0, THR_MAX), $urandom_range(0, THR_MAX),
                 $urandom_range(0, THR_MAX), $urandom_range(0, 1));
    run_mixed(120);
    settle();

    program_regs($urandom_range(0, 3000000), $urandom_range(0, 100000),
                 $urandom_range(0, 600000), $urandom_range(0, 100000),
                 $urandom_range(0, 600000), $urandom_range(0, 1));
    run_mixed(150);
    settle();

    if (ledger.mismatches == 0 && ledger.expected_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ibapfc_pkg.sv
hw/rtl/ibapfc_if.sv
hw/rtl/ingress_buffer_accounting_pfc.sv
tb/tb_top.sv
